// ===== sv/thsl_pkg.sv =====
// Shared types, codes and microcode table of the triggered hold slew limiter.
package thsl_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [31:0] RST_SLEW_STEP    = 32'd446;
    localparam logic [15:0] RST_SHAPE_AMOUNT = 16'd0;
    localparam logic [15:0] RST_ATTENUATION  = 16'd65535;
    localparam int          RST_TRIG_HIGH    = 2294;
    localparam int          RST_TRIG_LOW     = 0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SLEW_STEP    = 3'd0,
        REG_SHAPE_AMOUNT = 3'd1,
        REG_ATTENUATION  = 3'd2,
        REG_TRIGGER_HIGH = 3'd3,
        REG_TRIGGER_LOW  = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        MUL_SHAPE = 2'd0,
        MUL_SLEW  = 2'd1,
        MUL_ATTEN = 2'd2
    } t_mul_sel;

    typedef enum logic [1:0] {
        COND_NEXT      = 2'd0,
        COND_WAIT_IN   = 2'd1,
        COND_SKIP_ZERO = 2'd2,
        COND_WAIT_OUT  = 2'd3
    } t_cond;

    typedef logic [2:0] t_step;

    localparam t_step STEP_IDLE  = 3'd0;
    localparam t_step STEP_DIFF  = 3'd1;
    localparam t_step STEP_SHAPE = 3'd2;
    localparam t_step STEP_SLEW  = 3'd3;
    localparam t_step STEP_MOVE  = 3'd4;
    localparam t_step STEP_ATTEN = 3'd5;
    localparam t_step STEP_EMIT  = 3'd6;

    typedef struct packed {
        t_cond    cond;
        t_step    target;
        t_mul_sel mul_sel;
        logic     ld_in;
        logic     ld_diff;
        logic     ld_prod;
        logic     ld_run;
        logic     ld_out;
    } t_uword;

    typedef struct packed {
        logic in_fire;
        logic diff_zero;
        logic out_free;
    } t_seq_stat;

    function automatic t_uword ucode(input t_step step_idx);
        t_uword w;
        w = '{cond: COND_NEXT, target: STEP_IDLE, mul_sel: MUL_SHAPE,
              ld_in: 1'b0, ld_diff: 1'b0, ld_prod: 1'b0, ld_run: 1'b0, ld_out: 1'b0};
        case (step_idx)
            STEP_IDLE: begin
                w.cond  = COND_WAIT_IN;
                w.ld_in = 1'b1;
            end
            STEP_DIFF: begin
                w.cond    = COND_SKIP_ZERO;
                w.target  = STEP_ATTEN;
                w.ld_diff = 1'b1;
            end
            STEP_SHAPE: begin
                w.mul_sel = MUL_SHAPE;
                w.ld_prod = 1'b1;
            end
            STEP_SLEW: begin
                w.mul_sel = MUL_SLEW;
                w.ld_prod = 1'b1;
            end
            STEP_MOVE: begin
                w.ld_run = 1'b1;
            end
            STEP_ATTEN: begin
                w.mul_sel = MUL_ATTEN;
                w.ld_prod = 1'b1;
            end
            STEP_EMIT: begin
                w.cond   = COND_WAIT_OUT;
                w.target = STEP_IDLE;
                w.ld_out = 1'b1;
            end
            default: begin
                w.cond = COND_NEXT;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== sv/thsl_if.sv =====
// Handshake channel interfaces: input items, result items and register writes.
interface thsl_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] trigger_level;
    logic signed [SAMPLE_BITS-1:0] noise_sample;

    modport source(output valid, trigger_level, noise_sample, input ready);
    modport sink(input valid, trigger_level, noise_sample, output ready);
endinterface

interface thsl_out_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] slewed_out;
    logic signed [SAMPLE_BITS-1:0] held_target;
    logic                          fired;

    modport source(output valid, slewed_out, held_target, fired, input ready);
    modport sink(input valid, slewed_out, held_target, fired, output ready);
endinterface

interface thsl_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [thsl_pkg::CFG_IDX_W-1:0]   index;
    logic [thsl_pkg::CFG_DATA_W-1:0]  data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ===== sv/triggered_hold_slew_limiter.sv =====
// Top level: triggered sample and hold with a shaped slew limiter.
// Each input item (trigger level, noise sample) runs through a seven-step
// microprogram on one shared multiplier: wait for the item, difference, shape
// product, step product, move, attenuation product and result. When the running
// value already sits on its target, the shape and step products and the move
// are skipped. The next item is taken once the previous one reaches the result
// register, so no new item is taken while one is in work; a stalled sink holds
// the sequencer on the result step. Register writes are taken every cycle; make
// them only while no item is in work.
module triggered_hold_slew_limiter #(
    parameter int SAMPLE_BITS   = 16,
    parameter int FRACTION_BITS = 16
) (
    input logic            i_clk,
    input logic            i_rst_n,
    thsl_in_if.sink        i_in,
    thsl_out_if.source     o_out,
    thsl_cfg_if.sink       i_cfg
);

    localparam int S   = SAMPLE_BITS;
    localparam int F   = FRACTION_BITS;
    localparam int RW  = S + F;
    localparam int DW  = RW + 1;
    localparam int MA  = (RW > 33) ? RW : 33;
    localparam int MB  = (F + 3 > 18) ? F + 3 : 18;
    localparam int PW  = MA + MB;
    localparam int ONE = 1 << F;
    localparam logic signed [PW-1:0] SMAX = PW'((64'sd1 <<< (S - 1)) - 64'sd1);
    localparam logic signed [PW-1:0] SMIN = -SMAX - PW'(1);

    logic [31:0]           r_slew;
    logic [15:0]           r_shape;
    logic [15:0]           r_att;
    logic signed [S-1:0]   r_thr_hi;
    logic signed [S-1:0]   r_thr_lo;

    logic                  r_armed;
    logic signed [S-1:0]   r_target;
    logic                  r_fired;
    logic signed [RW-1:0]  r_running;
    logic [RW-1:0]         r_mag;
    logic                  r_neg;
    logic signed [PW-1:0]  r_prod;

    logic                  r_out_valid;
    logic signed [S-1:0]   r_out_slewed;
    logic signed [S-1:0]   r_out_target;
    logic                  r_out_fired;

    thsl_pkg::t_uword      uw;
    thsl_pkg::t_seq_stat   stat;

    logic                  in_fire;
    logic                  out_free;
    logic signed [RW-1:0]  goal;
    logic signed [DW-1:0]  diff;
    logic signed [DW-1:0]  diff_neg;
    logic [F:0]            dnorm;
    logic signed [F+1:0]   dm1;
    logic [16:0]           unit_shape;
    logic [16:0]           unit_att;
    logic signed [F+2:0]   fac_s;
    logic [F+1:0]          factor;
    logic signed [MA-1:0]  mul_a;
    logic signed [MB-1:0]  mul_b;
    logic signed [PW-1:0]  mul_p;
    logic                  reach;
    logic signed [RW-1:0]  run_step;
    logic signed [PW-1:0]  res;
    logic signed [S-1:0]   sat_out;

    thsl_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_uword (uw)
    );

    assign i_in.ready  = uw.ld_in;
    assign in_fire     = i_in.valid && i_in.ready;
    assign out_free    = !r_out_valid || o_out.ready;
    assign i_cfg.ready = 1'b1;

    assign goal     = $signed({r_target, {F{1'b0}}});
    assign diff     = DW'(goal) - DW'(r_running);
    assign diff_neg = -diff;

    assign stat.in_fire   = in_fire;
    assign stat.diff_zero = (diff == '0);
    assign stat.out_free  = out_free;

    assign dnorm      = r_mag[RW-1:S-1];
    assign dm1        = $signed({1'b0, dnorm}) - $signed((F + 2)'(ONE));
    assign unit_shape = {1'b0, r_shape} + 17'(r_shape[15]);
    assign unit_att   = {1'b0, r_att} + 17'(r_att[15]);

    assign fac_s  = (F + 3)'(r_prod >>> 16) + $signed((F + 3)'(ONE));
    assign factor = fac_s[F+2] ? '0 : fac_s[F+1:0];

    always_comb begin
        case (uw.mul_sel)
            thsl_pkg::MUL_SHAPE: begin
                mul_a = MA'($signed({1'b0, unit_shape}));
                mul_b = MB'(dm1);
            end
            thsl_pkg::MUL_SLEW: begin
                mul_a = MA'($signed({1'b0, r_slew}));
                mul_b = MB'($signed({1'b0, factor}));
            end
            thsl_pkg::MUL_ATTEN: begin
                mul_a = MA'(r_running);
                mul_b = MB'($signed({1'b0, unit_att}));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = PW'(mul_a) * PW'(mul_b);

    assign reach    = r_prod[PW-1:F] >= (PW - F)'(r_mag);
    assign run_step = $signed(r_prod[RW+F-1:F]);

    assign res = r_prod >>> (16 + F);

    always_comb begin
        if (res > SMAX) begin
            sat_out = SMAX[S-1:0];
        end else if (res < SMIN) begin
            sat_out = SMIN[S-1:0];
        end else begin
            sat_out = res[S-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slew      <= thsl_pkg::RST_SLEW_STEP;
            r_shape     <= thsl_pkg::RST_SHAPE_AMOUNT;
            r_att       <= thsl_pkg::RST_ATTENUATION;
            r_thr_hi    <= S'(thsl_pkg::RST_TRIG_HIGH);
            r_thr_lo    <= S'(thsl_pkg::RST_TRIG_LOW);
            r_armed     <= 1'b0;
            r_target    <= '0;
            r_fired     <= 1'b0;
            r_running   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    thsl_pkg::REG_SLEW_STEP:    r_slew   <= i_cfg.data;
                    thsl_pkg::REG_SHAPE_AMOUNT: r_shape  <= i_cfg.data[15:0];
                    thsl_pkg::REG_ATTENUATION:  r_att    <= i_cfg.data[15:0];
                    thsl_pkg::REG_TRIGGER_HIGH: r_thr_hi <= $signed(i_cfg.data[S-1:0]);
                    thsl_pkg::REG_TRIGGER_LOW:  r_thr_lo <= $signed(i_cfg.data[S-1:0]);
                    default: ;
                endcase
            end

            if (in_fire) begin
                r_fired <= 1'b0;
                if (!r_armed) begin
                    if (i_in.trigger_level >= r_thr_hi) begin
                        r_armed  <= 1'b1;
                        r_fired  <= 1'b1;
                        r_target <= i_in.noise_sample;
                    end
                end else if (i_in.trigger_level <= r_thr_lo) begin
                    r_armed <= 1'b0;
                end
            end

            if (uw.ld_run) begin
                if (reach) begin
                    r_running <= goal;
                end else if (r_neg) begin
                    r_running <= r_running - run_step;
                end else begin
                    r_running <= r_running + run_step;
                end
            end

            if (uw.ld_out && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (uw.ld_diff) begin
            r_neg <= diff[DW-1];
            r_mag <= diff[DW-1] ? diff_neg[RW-1:0] : diff[RW-1:0];
        end
        if (uw.ld_prod) begin
            r_prod <= mul_p;
        end
        if (uw.ld_out && out_free) begin
            r_out_slewed <= sat_out;
            r_out_target <= r_target;
            r_out_fired  <= r_fired;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.slewed_out  = r_out_slewed;
    assign o_out.held_target = r_out_target;
    assign o_out.fired       = r_out_fired;

endmodule

// ===== sv/thsl_seq.sv =====
// Microcode sequencer: step counter, control ROM and conditional jumps.
module thsl_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  thsl_pkg::t_seq_stat i_stat,
    output thsl_pkg::t_uword    o_uword
);

    thsl_pkg::t_step  r_step;
    thsl_pkg::t_step  n_step;
    thsl_pkg::t_uword uw;

    assign uw      = thsl_pkg::ucode(r_step);
    assign o_uword = uw;

    always_comb begin
        case (uw.cond)
            thsl_pkg::COND_NEXT:      n_step = r_step + 3'd1;
            thsl_pkg::COND_WAIT_IN:   n_step = i_stat.in_fire ? r_step + 3'd1 : r_step;
            thsl_pkg::COND_SKIP_ZERO: n_step = i_stat.diff_zero ? uw.target : r_step + 3'd1;
            thsl_pkg::COND_WAIT_OUT:  n_step = i_stat.out_free ? uw.target : r_step;
            default:                  n_step = thsl_pkg::STEP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= thsl_pkg::STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

// ===== sv/thsl_chk.sv =====
// Port-level checker for the triggered hold slew limiter, bound to the top level.
module thsl_chk #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic signed [SAMPLE_BITS-1:0] i_out_slewed,
    input logic signed [SAMPLE_BITS-1:0] i_out_target,
    input logic                          i_out_fired
);

    logic in_fire;

    assign in_fire  = i_in_valid && i_in_ready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_slewed)
            && $stable(i_out_target) && $stable(i_out_fired))
        else $error("result item changed while stalled");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !i_in_ready)
        else $error("second item taken while one is in work");

    a_item_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !i_in_ready [*3])
        else $error("next item taken before the shortest program finished");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind triggered_hold_slew_limiter thsl_chk #(.SAMPLE_BITS(SAMPLE_BITS)) u_thsl_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_slewed (o_out.slewed_out),
    .i_out_target (o_out.held_target),
    .i_out_fired  (o_out.fired)
);

// ===== tb/thsl_tb_pkg.sv =====
`timescale 1ns / 1ps
// Scoreboard of the triggered hold slew limiter: output predictor and pending result items.
package thsl_tb_pkg;
    import thsl_pkg::*;

    localparam int SAMPLE_W = 16;
    localparam int FRAC_W   = 16;

    typedef struct {
        logic signed [SAMPLE_W-1:0] slewed_out;
        logic signed [SAMPLE_W-1:0] held_target;
        logic                       fired;
    } t_slew_result;

    class slew_hold_scoreboard;
        logic [31:0]                slew_step;
        logic [15:0]                shape_amount;
        logic [15:0]                attenuation;
        logic signed [SAMPLE_W-1:0] trig_high;
        logic signed [SAMPLE_W-1:0] trig_low;
        bit                         armed_high;
        logic signed [SAMPLE_W-1:0] target_value;
        longint                     running_value;
        t_slew_result               pending_results[$];
        int                         error_count;

        function new();
            slew_step     = RST_SLEW_STEP;
            shape_amount  = RST_SHAPE_AMOUNT;
            attenuation   = RST_ATTENUATION;
            trig_high     = SAMPLE_W'(RST_TRIG_HIGH);
            trig_low      = SAMPLE_W'(RST_TRIG_LOW);
            armed_high    = 1'b0;
            target_value  = '0;
            running_value = 0;
            error_count   = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                REG_SLEW_STEP:    slew_step    = data;
                REG_SHAPE_AMOUNT: shape_amount = data[15:0];
                REG_ATTENUATION:  attenuation  = data[15:0];
                REG_TRIGGER_HIGH: trig_high    = data[SAMPLE_W-1:0];
                REG_TRIGGER_LOW:  trig_low     = data[SAMPLE_W-1:0];
                default: ;
            endcase
        endfunction

        // 65535 maps to exactly one in Q16
        function longint unit_gain(logic [15:0] v);
            return longint'(v) + longint'(v >> 15);
        endfunction

        function t_slew_result predict_sample(logic signed [SAMPLE_W-1:0] level,
                                              logic signed [SAMPLE_W-1:0] noise);
            t_slew_result     r;
            longint           goal;
            longint           diff;
            longint           dnorm;
            longint           factor;
            longint           scaled;
            longint unsigned  mag;
            longint unsigned  step;
            r.fired = 1'b0;
            if (!armed_high) begin
                if (level >= trig_high) begin
                    armed_high   = 1'b1;
                    r.fired      = 1'b1;
                    target_value = noise;
                end
            end else if (level <= trig_low) begin
                armed_high = 1'b0;
            end
            goal = longint'(target_value) * (longint'(1) << FRAC_W);
            diff = goal - running_value;
            if (diff != 0) begin
                mag    = (diff < 0) ? -diff : diff;
                dnorm  = longint'(mag >> (SAMPLE_W - 1));
                factor = (longint'(1) << FRAC_W)
                         + ((unit_gain(shape_amount) * (dnorm - (longint'(1) << FRAC_W))) >>> 16);
                if (factor < 0) begin
                    factor = 0;
                end
                step = (longint'(slew_step) * factor) >> FRAC_W;
                if (step >= mag) begin
                    running_value = goal;
                end else if (diff > 0) begin
                    running_value = running_value + longint'(step);
                end else begin
                    running_value = running_value - longint'(step);
                end
            end
            scaled = (running_value * unit_gain(attenuation)) >>> (16 + FRAC_W);
            if (scaled > 32767) begin
                scaled = 32767;
            end
            if (scaled < -32768) begin
                scaled = -32768;
            end
            r.slewed_out  = scaled[SAMPLE_W-1:0];
            r.held_target = target_value;
            return r;
        endfunction

        function void note_sample(logic signed [SAMPLE_W-1:0] level,
                                  logic signed [SAMPLE_W-1:0] noise);
            pending_results.push_back(predict_sample(level, noise));
        endfunction

        function void check_result(logic signed [SAMPLE_W-1:0] slewed_out,
                                   logic signed [SAMPLE_W-1:0] held_target,
                                   logic fired);
            t_slew_result e;
            if (pending_results.size() == 0) begin
                $display("%0t: result item with none pending: slewed_out %0d held_target %0d fired %0b",
                         $time, slewed_out, held_target, fired);
                error_count++;
                return;
            end
            e = pending_results.pop_front();
            if (slewed_out !== e.slewed_out) begin
                $display("%0t: slewed_out mismatch: expected %0d, actual %0d",
                         $time, e.slewed_out, slewed_out);
                error_count++;
            end
            if (held_target !== e.held_target) begin
                $display("%0t: held_target mismatch: expected %0d, actual %0d",
                         $time, e.held_target, held_target);
                error_count++;
            end
            if (fired !== e.fired) begin
                $display("%0t: fired mismatch: expected %0b, actual %0b", $time, e.fired, fired);
                error_count++;
            end
        endfunction
    endclass

endpackage

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top: drives the triggered hold slew limiter and checks every result item.
module tb_top;
    import thsl_pkg::*;
    import thsl_tb_pkg::*;

    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 20;
    localparam int RANDOM_ITEMS    = 2000;

    logic i_clk;
    logic i_rst_n;

    thsl_in_if  #(.SAMPLE_BITS(SAMPLE_W)) in_ch ();
    thsl_out_if #(.SAMPLE_BITS(SAMPLE_W)) out_ch ();
    thsl_cfg_if                           cfg_ch ();

    slew_hold_scoreboard sb;
    bit                  in_no_idle;
    bit                  out_no_idle;
    bit                  hold_off_req;
    int                  cur_high;
    int                  cur_low;
    int                  idle_cycles;

    triggered_hold_slew_limiter #(
        .SAMPLE_BITS(SAMPLE_W),
        .FRACTION_BITS(FRAC_W)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in(in_ch),
        .o_out(out_ch),
        .i_cfg(cfg_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int rand_gap();
        int r;
        r = $urandom_range(99, 0);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(3, 1);
        if (r < 98) return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_between(int lo, int hi);
        return SAMPLE_W'(lo + int'($urandom_range(hi - lo, 0)));
    endfunction

    task automatic send_sample(logic signed [SAMPLE_W-1:0] level,
                               logic signed [SAMPLE_W-1:0] noise);
        int gap;
        gap = in_no_idle ? 0 : rand_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.trigger_level <= level;
        in_ch.noise_sample  <= noise;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
        sb.note_sample(level, noise);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        @(posedge i_clk);
        while (cfg_ch.ready !== 1'b1) @(posedge i_clk);
        sb.write_register(index, data);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_settings(logic [31:0] slew, logic [31:0] shape, logic [31:0] atten,
                                  logic [31:0] high, logic [31:0] low);
        write_reg(REG_SLEW_STEP, slew);
        write_reg(REG_SHAPE_AMOUNT, shape);
        write_reg(REG_ATTENUATION, atten);
        write_reg(REG_TRIGGER_HIGH, high);
        write_reg(REG_TRIGGER_LOW, low);
        cur_high = int'($signed(high[SAMPLE_W-1:0]));
        cur_low  = int'($signed(low[SAMPLE_W-1:0]));
    endtask

    task automatic randomize_settings();
        logic [31:0] slew;
        logic [15:0] shape;
        logic [15:0] atten;
        int          t_hi;
        int          t_lo;
        case ($urandom_range(5, 0))
            0: slew = '0;
            1: slew = '1;
            2: slew = $urandom_range(64, 1);
            3: slew = $urandom_range(8191, 65);
            4: slew = $urandom_range(32'h0010_0000, 8192);
            default: slew = $urandom();
        endcase
        case ($urandom_range(3, 0))
            0: shape = '0;
            1: shape = '1;
            default: shape = 16'($urandom());
        endcase
        case ($urandom_range(3, 0))
            0: atten = '0;
            1: atten = '1;
            default: atten = 16'($urandom());
        endcase
        case ($urandom_range(4, 0))
            0: begin
                t_hi = 32767;
                t_lo = -32768;
            end
            1: begin
                t_hi = -32768;
                t_lo = 32767;
            end
            2: begin
                t_hi = int'($urandom_range(30000, 0)) - 15000;
                t_lo = t_hi + int'($urandom_range(2000, 0));
            end
            3: begin
                t_hi = int'($urandom_range(65535, 0)) - 32768;
                t_lo = int'($urandom_range(65535, 0)) - 32768;
            end
            default: begin
                t_hi = int'($urandom_range(16000, 0)) - 8000;
                t_lo = t_hi - int'($urandom_range(8000, 1));
            end
        endcase
        apply_settings(slew, {16'($urandom()), shape}, {16'($urandom()), atten},
                       {16'($urandom()), 16'(t_hi)}, {16'($urandom()), 16'(t_lo)});
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            sb.check_result(out_ch.slewed_out, out_ch.held_target, out_ch.fired);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
                || (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
                || (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else begin
                stall = out_no_idle ? 0 : rand_gap();
                if (stall > 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(8, 1)) @(posedge i_clk);
        end
    end

    initial begin
        int                         items_sent;
        int                         phase_idx;
        int                         phase_len;
        int                         hold_left;
        bit                         want_high;
        logic signed [SAMPLE_W-1:0] level;
        logic signed [SAMPLE_W-1:0] noise;
        sb                  = new();
        in_no_idle          = 1'b0;
        out_no_idle         = 1'b0;
        hold_off_req        = 1'b0;
        cur_high            = RST_TRIG_HIGH;
        cur_low             = RST_TRIG_LOW;
        i_rst_n             <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.trigger_level <= '0;
        in_ch.noise_sample  <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= '0;
        cfg_ch.data         <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: fire, hold, re-arm, fire exactly at the threshold
        send_sample(16'sd0, 16'sd100);
        send_sample(16'h7FFF, 16'h7FFF);
        send_sample(16'h7FFF, 16'sd5);
        send_sample(16'h8000, -16'sd7);
        send_sample(16'sd2294, 16'h8000);
        send_sample(16'sd0, 16'sd1);
        send_sample(16'sd2293, 16'sd50);
        send_sample(16'sd2294, -16'sd1);
        drain_results();

        // widest step, full shape, unity gain, extreme thresholds
        apply_settings('1, 32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_7FFF, 32'h0000_8000);
        send_sample(16'h7FFF, 16'h7FFF);
        send_sample(16'h8000, 16'sd0);
        send_sample(16'h7FFF, 16'h8000);
        send_sample(16'sd0, 16'sd0);
        drain_results();

        // zero step holds still; crossed thresholds; upper register bits ignored
        apply_settings('0, 32'h1234_8000, 32'hABCD_0000, 32'hFFFF_FF9C, 32'h1234_0064);
        send_sample(-16'sd100, 16'sd1234);
        send_sample(16'sd0, 16'sd5);
        send_sample(-16'sd100, 16'sd99);
        drain_results();

        // writes to unmapped indexes leave the settings alone
        for (int k = int'(REG_TRIGGER_LOW) + 1; k < (1 << CFG_IDX_W); k++) begin
            write_reg(k[CFG_IDX_W-1:0], $urandom());
        end
        apply_settings(32'h0004_0000, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
        send_sample(16'h8000, 16'sd20000);
        send_sample(16'h8000, 16'sd3);
        send_sample(16'h8000, -16'sd20000);
        send_sample(16'sd0, 16'sd0);
        drain_results();

        items_sent = 0;
        phase_idx  = 0;
        hold_left  = 0;
        want_high  = 1'b0;
        while (items_sent < RANDOM_ITEMS) begin
            drain_results();
            randomize_settings();
            in_no_idle   = ($urandom_range(4, 0) == 0);
            out_no_idle  = ($urandom_range(4, 0) == 0);
            hold_off_req = (phase_idx % 6 == 2);
            phase_len    = $urandom_range(160, 40);
            repeat (phase_len) begin
                if (hold_left == 0) begin
                    want_high = !want_high;
                    hold_left = $urandom_range(4, 1);
                end
                hold_left--;
                if ($urandom_range(9, 0) < 7) begin
                    level = want_high ? pick_between(cur_high, 32767)
                                      : pick_between(-32768, cur_low);
                end else begin
                    level = SAMPLE_W'($urandom());
                end
                case ($urandom_range(7, 0))
                    0: noise = 16'h7FFF;
                    1: noise = 16'h8000;
                    default: noise = SAMPLE_W'($urandom());
                endcase
                send_sample(level, noise);
                items_sent++;
            end
            phase_idx++;
        end
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.error_count == 0 && sb.pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
